// ----- rtl/sss_pkg.sv -----
// substring search package: request and result types, register indexes,
// pattern byte selection and cell control. No dependencies.
`timescale 1ns / 1ps

package sss_pkg;

	localparam int BYTE_BITS      = 8;
	localparam int PATTERN_BYTES  = 16;
	localparam int LENGTH_BITS    = 5;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int START_BITS     = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd2;

	typedef logic [BYTE_BITS-1:0] byte_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] text_byte;
		logic                 text_last;
	} text_req_t;

	typedef struct packed {
		logic                  found;
		logic [START_BITS-1:0] match_start;
	} result_t;

	// control shared by every cell of the window chain
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic byte_t pattern_byte(input logic [CFG_DATA_BITS-1:0] lo,
			input logic [CFG_DATA_BITS-1:0] hi, input logic [3:0] idx);
		byte_t b;
		if (idx[3]) begin
			b = hi[{idx[2:0], 3'b000} +: BYTE_BITS];
		end else begin
			b = lo[{idx[2:0], 3'b000} +: BYTE_BITS];
		end
		return b;
	endfunction

endpackage

// ----- rtl/sss_cell.sv -----
// one cell of the text window: holds one earlier byte, passes it on
// and compares it with its pattern byte. Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sss_pkg::cell_ctrl_t ctrl,
	input  sss_pkg::byte_t    d,
	input  sss_pkg::byte_t    pattern,
	input  logic              active,
	output sss_pkg::byte_t    q,
	output logic              hit
);

	sss_pkg::byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= d;
		end
	end

	assign q   = byte_q;
	// cells beyond the pattern length always agree
	assign hit = !active || (byte_q == pattern);

endmodule

// ----- rtl/substring_search_stream.sv -----
// streaming first-occurrence substring search, top level.
// Depends on sss_pkg and sss_cell.
`timescale 1ns / 1ps

// channel   direction  handshake                payload
// in        input      in_valid / in_stall      text_req_t  (text_byte, text_last)
// out       output     out_valid / out_stall    result_t    (found, match_start)
// cfg       input      cfg_write                cfg_index, cfg_data
//
// one text byte per cycle; the result of a byte is registered and appears
// the cycle after the byte is taken. The compare is combinational across the
// chain of window cells, so throughput is one byte per clock while in_stall is low.
// in_stall is high only while a result is held and out_stall is high.
// reset clears the window, position count, match flag and registers
// (pattern_length resets to 1).

module substring_search_stream #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  sss_pkg::text_req_t                     in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output sss_pkg::result_t                       out_data,
	input  logic                                   cfg_write,
	input  logic [sss_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [sss_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	logic [sss_pkg::CFG_DATA_BITS-1:0] pattern_low_q;
	logic [sss_pkg::CFG_DATA_BITS-1:0] pattern_high_q;
	logic [sss_pkg::LENGTH_BITS-1:0]   pattern_length_q;

	logic [POSITION_BITS-1:0] byte_count_q;
	logic                     matched_q;
	logic                     out_valid_q;
	sss_pkg::result_t         out_data_q;

	logic [sss_pkg::LENGTH_BITS-1:0] len_eff;
	logic [sss_pkg::LENGTH_BITS-1:0] len_m1_w;
	logic [3:0]                      len_m1;
	logic [MAX_PATTERN-1:0]          hit;
	sss_pkg::byte_t                  chain [MAX_PATTERN];
	sss_pkg::cell_ctrl_t             ctrl;
	logic                            accept;
	logic                            count_ok;
	logic                            match_now;
	logic                            produce;
	logic [POSITION_BITS-1:0]        start_pos;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= sss_pkg::LENGTH_BITS'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				sss_pkg::REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				sss_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				sss_pkg::REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[sss_pkg::LENGTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamp length into 1..MAX_PATTERN
	always_comb begin
		priority if (pattern_length_q == '0) begin
			len_eff = sss_pkg::LENGTH_BITS'(1);
		end else if (pattern_length_q > sss_pkg::LENGTH_BITS'(MAX_PATTERN)) begin
			len_eff = sss_pkg::LENGTH_BITS'(MAX_PATTERN);
		end else begin
			len_eff = pattern_length_q;
		end
	end

	assign len_m1_w = len_eff - sss_pkg::LENGTH_BITS'(1);
	assign len_m1   = len_m1_w[3:0];

	assign accept = in_valid && !in_stall;

	// current byte lines up with the last pattern byte
	assign chain[0] = in_data.text_byte;
	assign hit[0]   = in_data.text_byte ==
		sss_pkg::pattern_byte(pattern_low_q, pattern_high_q, len_m1);

	// window cell j holds the byte j+1 places back
	for (genvar j = 0; j < MAX_PATTERN - 1; j++) begin : g_cell
		logic [sss_pkg::LENGTH_BITS-1:0] idx_w;
		logic                            active;
		sss_pkg::byte_t                  pat;

		assign active = sss_pkg::LENGTH_BITS'(j + 2) <= len_eff;
		assign idx_w  = len_eff - sss_pkg::LENGTH_BITS'(j + 2);
		assign pat    = sss_pkg::pattern_byte(pattern_low_q, pattern_high_q, idx_w[3:0]);

		if (j < MAX_PATTERN - 2) begin : g_mid
			sss_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.d       (chain[j]),
				.pattern (pat),
				.active  (active),
				.q       (chain[j+1]),
				.hit     (hit[j+1])
			);
		end else begin : g_end
			sss_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.d       (chain[j]),
				.pattern (pat),
				.active  (active),
				.q       (),
				.hit     (hit[j+1])
			);
		end
	end

	// enough bytes in this text to cover the pattern
	assign count_ok  = byte_count_q >= POSITION_BITS'(len_m1);
	assign match_now = count_ok && (&hit);
	assign produce   = accept && !matched_q && (match_now || in_data.text_last);
	assign start_pos = byte_count_q - POSITION_BITS'(len_m1);

	assign ctrl.shift = accept && !matched_q && !match_now && !in_data.text_last;
	assign ctrl.clear = accept && in_data.text_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			matched_q    <= 1'b0;
		end else if (ctrl.clear) begin
			byte_count_q <= '0;
			matched_q    <= 1'b0;
		end else begin
			if (ctrl.shift && (byte_count_q != '1)) begin
				byte_count_q <= byte_count_q + POSITION_BITS'(1);
			end
			if (accept && !matched_q && match_now) begin
				matched_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_data_q.found       <= match_now;
			out_data_q.match_start <= match_now ? sss_pkg::START_BITS'(start_pos) : '0;
		end
	end

	assign in_stall  = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a match before the last byte blocks further results in this text
	a_match_latches: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !matched_q && match_now && !in_data.text_last |=> matched_q)
		else $error("match flag not set after first match");

	// the last byte of an unmatched text always gives a result
	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !matched_q && in_data.text_last |=> out_valid)
		else $error("no result for last byte");

	// the last byte restarts the stream state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.text_last |=> (byte_count_q == '0) && !matched_q)
		else $error("stream state not cleared after last byte");

	// a not-found result carries a zero position
	a_nofind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.match_start == '0)
		else $error("not-found result with nonzero position");

endmodule

// ----- test/substring_search_stream_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for substring_search_stream: streams text requests,
// writes the pattern registers and checks every search result against a predictor.
// Depends on sss_pkg and the substring_search_stream rtl.

module substring_search_stream_test;

	localparam int WINDOW_DEPTH    = 15;
	localparam int SETTLE_CYCLES   = 4;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_ITEMS    = 700;
	localparam int RANDOM_TEXTS    = 60;
	localparam int LONG_TEXT_BYTES = 150;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sss_pkg::text_req_t in_data;
	logic out_valid;
	logic out_stall;
	sss_pkg::result_t out_data;
	logic cfg_write;
	logic [sss_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [sss_pkg::CFG_DATA_BITS-1:0] cfg_data;

	// predictor copy of the registers and the stream state
	logic [sss_pkg::CFG_DATA_BITS-1:0] pat_lo;
	logic [sss_pkg::CFG_DATA_BITS-1:0] pat_hi;
	logic [sss_pkg::LENGTH_BITS-1:0] pat_len;
	sss_pkg::byte_t window_q [WINDOW_DEPTH];
	logic [sss_pkg::START_BITS-1:0] position;
	logic matched;

	sss_pkg::result_t expected_results [$];
	int error_count;
	int cycle_count;
	int items_sent;
	int texts_sent;
	bit steady_flow;
	bit hold_off_pending;
	sss_pkg::byte_t alphabet [4];

	substring_search_stream u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int used_len();
		if (pat_len == 0)
			return 1;
		if (pat_len > sss_pkg::PATTERN_BYTES)
			return sss_pkg::PATTERN_BYTES;
		return int'(pat_len);
	endfunction

	function automatic void clear_search();
		foreach (window_q[i])
			window_q[i] = '0;
		position = '0;
		matched = 1'b0;
	endfunction

	// returns 1 when the byte yields a result
	function automatic bit search_step(input sss_pkg::byte_t cur, input logic last,
			output sss_pkg::result_t res);
		int len;
		int k;
		bit hit;
		logic [2*sss_pkg::CFG_DATA_BITS-1:0] pattern;
		sss_pkg::byte_t text_b;
		res = '0;
		len = used_len();
		if (matched) begin
			if (last)
				clear_search();
			return 1'b0;
		end
		pattern = {pat_hi, pat_lo};
		hit = (int'(position) >= len - 1);
		for (k = 0; k < len; k++) begin
			text_b = (k == 0) ? cur : window_q[k-1];
			if (text_b != pattern[8*(len-1-k) +: 8])
				hit = 1'b0;
		end
		if (hit) begin
			res.found = 1'b1;
			res.match_start = position - sss_pkg::START_BITS'(len - 1);
			if (last)
				clear_search();
			else
				matched = 1'b1;
			return 1'b1;
		end
		if (last) begin
			clear_search();
			return 1'b1;
		end
		for (k = WINDOW_DEPTH - 1; k > 0; k--)
			window_q[k] = window_q[k-1];
		window_q[0] = cur;
		if (position != '1)
			position++;
		return 1'b0;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: random stall runs, or one long hold-off when asked
	initial begin
		int run_left;
		logic level;
		run_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_pending = 1'b0;
				out_stall <= 1'b0;
				run_left = 0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				level = steady_flow ? 1'b0 : ($urandom_range(0, 2) == 0);
				if (level)
					run_left = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50)
						: $urandom_range(0, 2);
				else
					run_left = $urandom_range(0, 6);
				out_stall <= level;
			end
		end
	end

	always @(posedge clk) begin
		sss_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: found %0b match_start %0d",
					out_data.found, out_data.match_start);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, out_data.found);
					error_count++;
				end
				if (out_data.match_start !== want.match_start) begin
					$error("match_start: expected %0d, got %0d",
						want.match_start, out_data.match_start);
					error_count++;
				end
			end
		end
	end

	task automatic send_byte(input sss_pkg::byte_t value, input logic last);
		sss_pkg::text_req_t req;
		sss_pkg::result_t res;
		int gap;
		req.text_byte = value;
		req.text_last = last;
		@(negedge clk);
		in_data <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (search_step(value, last, res))
			expected_results.push_back(res);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_text(input sss_pkg::byte_t text_q [$]);
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	// bytes that carry no result may still be in flight, so keep waiting once the results drain
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sss_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [sss_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		unique case (idx)
			sss_pkg::REG_PATTERN_LOW: pat_lo = value;
			sss_pkg::REG_PATTERN_HIGH: pat_hi = value;
			sss_pkg::REG_PATTERN_LENGTH: pat_len = value[sss_pkg::LENGTH_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic write_pattern(input logic [sss_pkg::CFG_DATA_BITS-1:0] lo,
			input logic [sss_pkg::CFG_DATA_BITS-1:0] hi, input int length);
		wait_idle();
		write_reg(sss_pkg::REG_PATTERN_LOW, lo);
		write_reg(sss_pkg::REG_PATTERN_HIGH, hi);
		write_reg(sss_pkg::REG_PATTERN_LENGTH, sss_pkg::CFG_DATA_BITS'(length));
	endtask

	// default pattern after reset is one zero byte
	task automatic test_reset_pattern();
		send_text('{8'hFF, 8'h00, 8'h00, 8'hFF});
		send_text('{8'h7E});
	endtask

	// oversized length register clamps to the full pattern; match on the last byte
	task automatic test_full_pattern();
		write_pattern('1, '0, 31);
		send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
	endtask

	task automatic test_short_and_trailing();
		write_pattern(64'h0000_0000_0063_6261, {$urandom, $urandom}, 3);
		send_text('{8'h61, 8'h62});
		// bytes after the match are dropped and the last one clears the window
		send_text('{8'h78, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62});
		send_text('{8'h63});
		send_text('{8'h61, 8'h62, 8'h63});
		// zero length behaves as one byte
		write_pattern(64'h0000_0000_0063_6261, pat_hi, 0);
		send_text('{8'h7A, 8'h61});
	endtask

	// pattern change between two bytes of one text keeps the stream state
	task automatic test_config_mid_text();
		write_pattern(64'h0000_0000_0000_6261, pat_hi, 2);
		send_byte(8'h61, 1'b0);
		write_pattern(64'h0000_0000_0000_0071, pat_hi, 1);
		send_byte(8'h71, 1'b1);
		texts_sent++;
	endtask

	// long text with the match far from the start, streamed back to back
	task automatic test_long_text();
		steady_flow = 1'b1;
		write_pattern(64'h0000_0000_0000_0201, pat_hi, 2);
		repeat (LONG_TEXT_BYTES)
			send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b1);
		texts_sent++;
		send_text('{8'h01, 8'h02});
		wait_idle();
		steady_flow = 1'b0;
	endtask

	// long receiver hold-off while single byte texts keep coming
	task automatic test_output_hold_off();
		sss_pkg::byte_t value;
		write_pattern({$urandom, 24'($urandom), 8'h80}, {$urandom, $urandom}, 1);
		steady_flow = 1'b1;
		hold_off_pending = 1'b1;
		repeat (40) begin
			value = ($urandom_range(0, 1) == 0) ? 8'h80 : sss_pkg::byte_t'($urandom);
			send_text('{value});
		end
		wait_idle();
		steady_flow = 1'b0;
	endtask

	task automatic test_random_texts();
		int phase;
		int phase_end;
		int len;
		int text_len;
		int pos;
		int r;
		bit wide;
		logic [2*sss_pkg::CFG_DATA_BITS-1:0] pattern;
		sss_pkg::byte_t text_q [$];
		phase = 0;
		while (items_sent < RANDOM_ITEMS || texts_sent < RANDOM_TEXTS) begin
			wide = (phase % 3 == 2);
			alphabet = '{8'h41, 8'h42, 8'h43, sss_pkg::byte_t'($urandom)};
			r = $urandom_range(0, 9);
			if (phase == 0)
				len = 16;
			else if (phase == 1)
				len = 1;
			else if (r == 0)
				len = $urandom_range(17, 31);
			else if (r == 1)
				len = 0;
			else
				len = $urandom_range(1, 16);
			pattern = {$urandom, $urandom, $urandom, $urandom};
			if (!wide)
				for (int i = 0; i < sss_pkg::PATTERN_BYTES; i++)
					pattern[8*i +: 8] = alphabet[$urandom_range(0, 3)];
			write_pattern(pattern[sss_pkg::CFG_DATA_BITS-1:0],
				pattern[2*sss_pkg::CFG_DATA_BITS-1:sss_pkg::CFG_DATA_BITS], len);
			steady_flow = (phase == 3);
			len = used_len();
			phase_end = items_sent + 100;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 9);
				text_len = $urandom_range(1, 2 * len + 8);
				text_q.delete();
				for (int i = 0; i < text_len; i++)
					text_q.push_back((wide || r >= 8) ? sss_pkg::byte_t'($urandom)
						: alphabet[$urandom_range(0, 3)]);
				if (r < 5 && text_len >= len) begin
					pos = $urandom_range(0, text_len - len);
					for (int j = 0; j < len; j++)
						text_q[pos+j] = pattern[8*j +: 8];
				end else if (r == 5 && len > 1) begin
					// near miss: text ends one byte short of the pattern
					text_q.delete();
					for (int j = 0; j < len - 1; j++)
						text_q.push_back(pattern[8*j +: 8]);
				end
				send_text(text_q);
			end
			phase++;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		items_sent = 0;
		texts_sent = 0;
		steady_flow = 1'b0;
		hold_off_pending = 1'b0;
		pat_lo = '0;
		pat_hi = '0;
		pat_len = 1;
		clear_search();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_pattern();
		test_full_pattern();
		test_short_and_trailing();
		test_config_mid_text();
		test_long_text();
		test_output_hold_off();
		test_random_texts();

		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
